// ----- sv/rnf_pkg.sv -----
// Package for the RSSI nearest-fingerprint locator.
// Holds the transaction payload types and fixed constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rnf_pkg;

    localparam logic       MODE_LOAD    = 1'b0;
    localparam logic       MODE_MEASURE = 1'b1;

    localparam logic [19:0] DIST_MAX    = 20'hFFFFF;
    localparam logic [19:0] LIMIT_RESET = 20'd99999;

    typedef struct packed {
        logic               mode;
        logic [3:0]         location_index;
        logic [2:0]         ap_index;
        logic signed [7:0]  rssi_value;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         location;
        logic               found;
        logic [19:0]        min_distance;
    } t_out_item;

endpackage

`default_nettype wire

// ----- sv/rssi_nearest_fingerprint_top.sv -----
// Top level of the RSSI nearest-fingerprint locator.
// Depends on rnf_pkg for the payload types and constants.
`timescale 1ns / 1ps
`default_nettype none

// Load transactions write one fingerprint table entry and measure transactions
// write one element of the measured vector. A measure transaction with last set
// starts a search that walks every table entry in row order through one shared
// bit-serial squarer: a read of the table and vector memories, the absolute
// difference, eight shift-add steps and an accumulate per entry, plus one
// compare per row. No input is taken during the search. The result sits in an
// output register, so load transactions are taken while it waits to be read.
module rssi_nearest_fingerprint_top #(
    parameter int NUM_ACCESS_POINTS = 8,
    parameter int NUM_LOCATIONS     = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [19:0]       i_cfg_wr_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire rnf_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output rnf_pkg::t_out_item     o_out_item
);
    import rnf_pkg::*;

    localparam int DEPTH = NUM_LOCATIONS * NUM_ACCESS_POINTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int APW   = (NUM_ACCESS_POINTS > 1) ? $clog2(NUM_ACCESS_POINTS) : 1;
    localparam int LW    = (NUM_LOCATIONS > 1) ? $clog2(NUM_LOCATIONS) : 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_DIF  = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_ACC  = 7'b0010000,
        S_CMP  = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state        r_state, n_state;

    logic [7:0]    r_tab_mem [DEPTH];
    logic [7:0]    r_vec_mem [NUM_ACCESS_POINTS];
    logic [7:0]    r_tab_q;
    logic [7:0]    r_vec_q;

    logic [19:0]   r_limit;
    logic [AW-1:0] r_addr;
    logic [APW-1:0] r_ap;
    logic [LW-1:0] r_loc;
    logic [2:0]    r_bit;
    logic [7:0]    r_mcand;
    logic [15:0]   r_prod;
    logic [19:0]   r_sum;
    logic [19:0]   r_best;
    logic [3:0]    r_best_loc;
    logic          r_found;
    logic          r_out_valid;
    t_out_item     r_out_item;

    logic          w_accept;
    logic          w_tab_wr;
    logic          w_vec_wr;
    logic [AW-1:0] w_waddr;
    logic [APW-1:0] w_vidx;
    logic [8:0]    w_diff;
    logic [7:0]    w_neg;
    logic [7:0]    w_mag;
    logic [8:0]    w_step;
    logic [20:0]   w_sum_ext;
    logic [19:0]   w_sum_sat;
    logic          w_last_ap;
    logic          w_last_loc;
    logic          w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_tab_wr = w_accept && (i_in_item.mode == MODE_LOAD)
                      && (int'(i_in_item.location_index) < NUM_LOCATIONS)
                      && (int'(i_in_item.ap_index) < NUM_ACCESS_POINTS);
    assign w_vec_wr = w_accept && (i_in_item.mode == MODE_MEASURE)
                      && (int'(i_in_item.ap_index) < NUM_ACCESS_POINTS);
    assign w_waddr  = AW'(int'(i_in_item.location_index) * NUM_ACCESS_POINTS
                          + int'(i_in_item.ap_index));
    assign w_vidx   = APW'(int'(i_in_item.ap_index));

    // Signed difference fits in 9 bits; its magnitude never exceeds 255.
    assign w_diff = {r_vec_q[7], r_vec_q} - {r_tab_q[7], r_tab_q};
    assign w_neg  = ~w_diff[7:0] + 8'd1;
    assign w_mag  = w_diff[8] ? w_neg : w_diff[7:0];

    // One shift-add step of the squarer: the low half holds the multiplier bits.
    assign w_step = {1'b0, r_prod[15:8]} + {1'b0, (r_prod[0] ? r_mcand : 8'd0)};

    assign w_sum_ext = {1'b0, r_sum} + {5'd0, r_prod};
    assign w_sum_sat = (w_sum_ext > {1'b0, DIST_MAX}) ? DIST_MAX : w_sum_ext[19:0];

    assign w_last_ap  = (r_ap == APW'(NUM_ACCESS_POINTS - 1));
    assign w_last_loc = (r_loc == LW'(NUM_LOCATIONS - 1));
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_in_item.mode == MODE_MEASURE) && i_in_item.last) begin
                    n_state = S_RD;
                end
            end
            S_RD:  n_state = S_DIF;
            S_DIF: n_state = S_MUL;
            S_MUL: begin
                if (r_bit == 3'd7) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: n_state = w_last_ap ? S_CMP : S_RD;
            S_CMP: n_state = w_last_loc ? S_FIN : S_RD;
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_tab_wr) begin
            r_tab_mem[w_waddr] <= i_in_item.rssi_value;
        end
        if (w_vec_wr) begin
            r_vec_mem[w_vidx] <= i_in_item.rssi_value;
        end
        if (r_state == S_RD) begin
            r_tab_q <= r_tab_mem[r_addr];
            r_vec_q <= r_vec_mem[r_ap];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
            r_addr      <= '0;
            r_ap        <= '0;
            r_loc       <= '0;
            r_bit       <= '0;
            r_sum       <= '0;
            r_best      <= '0;
            r_best_loc  <= '0;
            r_found     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_addr     <= '0;
                    r_ap       <= '0;
                    r_loc      <= '0;
                    r_sum      <= '0;
                    r_best     <= r_limit;
                    r_best_loc <= '0;
                    r_found    <= 1'b0;
                end
                S_DIF: begin
                    r_mcand <= w_mag;
                    r_prod  <= {8'd0, w_mag};
                    r_bit   <= '0;
                end
                S_MUL: begin
                    r_prod <= {w_step, r_prod[7:1]};
                    r_bit  <= r_bit + 3'd1;
                end
                S_ACC: begin
                    r_sum  <= w_sum_sat;
                    r_addr <= r_addr + AW'(1);
                    if (!w_last_ap) begin
                        r_ap <= r_ap + APW'(1);
                    end
                end
                S_CMP: begin
                    // Only a strictly smaller sum replaces the running minimum.
                    if (r_sum < r_best) begin
                        r_best     <= r_sum;
                        r_best_loc <= 4'(r_loc);
                        r_found    <= 1'b1;
                    end
                    r_sum <= '0;
                    r_ap  <= '0;
                    if (!w_last_loc) begin
                        r_loc <= r_loc + LW'(1);
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_item.location     <= r_best_loc;
                        r_out_item.found        <= r_found;
                        r_out_item.min_distance <= r_best;
                    end
                end
                default: begin
                    r_sum <= r_sum;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/rnf_checker.sv -----
// Port-level checker for the RSSI nearest-fingerprint locator, bound to the top.
// Depends on rnf_pkg for the payload types and constants.
`timescale 1ns / 1ps
`default_nettype none

module rnf_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               o_in_ready,
    input  wire rnf_pkg::t_in_item  i_in_item,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_ready,
    input  wire rnf_pkg::t_out_item o_out_item
);
    import rnf_pkg::*;

    // A result waiting for the consumer stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result changed or dropped while stalled");

    // A search transaction makes the block busy on the next cycle.
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_item.mode == MODE_MEASURE)
         && i_in_item.last) |=> !o_in_ready)
        else $error("input still ready after a search started");

    // With no location found the reported location is zero.
    a_not_found_loc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.found) |-> (o_out_item.location == 4'd0))
        else $error("location nonzero without a match");

    // A saturated sum can never win.
    a_found_not_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.found) |-> (o_out_item.min_distance != DIST_MAX))
        else $error("found set with a saturated distance");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind rssi_nearest_fingerprint_top rnf_checker u_rnf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for rssi_nearest_fingerprint_top: random and directed loads and
// measurements against a built-in nearest-location predictor, with random handshake stalls.
// Depends on rnf_pkg and the rssi_nearest_fingerprint_top RTL.
`timescale 1ns / 1ps

module tb;
    import rnf_pkg::*;

    localparam int NUM_AP        = 8;
    localparam int NUM_LOC       = 16;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 1500;
    localparam int HOLD_CYCLES   = 5000;
    localparam int CYCLE_LIMIT   = 12000000;
    localparam int MAX_REPORTS   = 10;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [19:0] cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    t_in_item    in_item     = '0;
    logic        out_ready   = 1'b0;
    logic        in_ready;
    logic        out_valid;
    t_out_item   out_item;

    // Predictor state: our own copy of the fingerprint table, measured vector and limit.
    logic signed [7:0] fp_table [NUM_LOC][NUM_AP];
    logic signed [7:0] meas_vec [NUM_AP];
    logic [19:0]       dist_limit = LIMIT_RESET;
    t_out_item         location_fixes_q [$];

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int hold_request  = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int mismatches    = 0;
    int cycle_count   = 0;

    rssi_nearest_fingerprint_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_item     (in_item),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_item    (out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_out_item predict_fix();
        t_out_item   fix;
        logic [19:0] best;
        int unsigned sum;
        int          diff;
        best = dist_limit;
        fix  = '0;
        for (int loc = 0; loc < NUM_LOC; loc++) begin
            sum = 0;
            for (int ap = 0; ap < NUM_AP; ap++) begin
                diff = int'(meas_vec[ap]) - int'(fp_table[loc][ap]);
                sum  = sum + diff * diff;
                if (sum > 32'(DIST_MAX))
                    sum = 32'(DIST_MAX);
            end
            // Strictly smaller only, so a tie keeps the lower location.
            if (sum < 32'(best)) begin
                best         = sum[19:0];
                fix.location = loc[3:0];
                fix.found    = 1'b1;
            end
        end
        fix.min_distance = best;
        return fix;
    endfunction

    task automatic apply_item(input t_in_item it);
        if (it.mode == MODE_LOAD) begin
            fp_table[it.location_index][it.ap_index] = it.rssi_value;
        end else begin
            meas_vec[it.ap_index] = it.rssi_value;
            if (it.last)
                location_fixes_q.push_back(predict_fix());
        end
    endtask

    function automatic t_in_item make_item(input logic mode, input logic [3:0] loc,
                                           input logic [2:0] ap, input logic [7:0] val,
                                           input logic last);
        t_in_item it;
        it.mode           = mode;
        it.location_index = loc;
        it.ap_index       = ap;
        it.rssi_value     = val;
        it.last           = last;
        return it;
    endfunction

    // Valid stays high after a transaction; the next call either keeps it or drops it.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
        apply_item(it);
        items_sent++;
    endtask

    task automatic send_vector(input logic [7:0][7:0] vec);
        int off;
        int ap;
        off = $urandom_range(NUM_AP - 1);
        for (int k = 0; k < NUM_AP; k++) begin
            ap = (k + off) % NUM_AP;
            send_item(make_item(MODE_MEASURE, 4'($urandom_range(15)), 3'(ap), vec[ap],
                                k == NUM_AP - 1));
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (location_fixes_q.size() != 0)
            @(posedge i_clk);
        // Loads are written when their transaction is taken; settle before a register write anyway.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [19:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en  <= 1'b0;
        dist_limit = value;
    endtask

    task automatic set_idling(input int in_pct, input int out_pct);
        in_idle_pct = in_pct;
        out_stall_pct <= out_pct;
    endtask

    task automatic check_fix(input t_out_item got);
        t_out_item want;
        if (location_fixes_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: unexpected fix loc %0d found %0b dist %0d", $realtime,
                         got.location, got.found, got.min_distance);
        end else begin
            want = location_fixes_q.pop_front();
            if (got.location !== want.location || got.found !== want.found ||
                got.min_distance !== want.min_distance) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: fix mismatch: expected loc %0d found %0b dist %0d, got loc %0d found %0b dist %0d",
                             $realtime, want.location, want.found, want.min_distance,
                             got.location, got.found, got.min_distance);
            end
        end
    endtask

    // Result side: checks each transaction and drives ready, including long hold-offs.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready)
            check_fix(out_item);
        if (hold_request != hold_seen) begin
            hold_seen <= hold_request;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // Every entry is written here so later searches never read an unwritten entry.
    // Rows 0 and 8 are identical to exercise the tie rule.
    task automatic test_table_fill();
        logic [7:0] val;
        set_idling(0, 0);
        for (int loc = 0; loc < NUM_LOC; loc++) begin
            for (int ap = 0; ap < NUM_AP; ap++) begin
                if (loc == 0 || loc == 8)
                    val = 8'h7F;
                else if (loc == NUM_LOC - 1)
                    val = 8'h80;
                else
                    val = 8'($urandom_range(255));
                send_item(make_item(MODE_LOAD, 4'(loc), 3'(ap), val, 1'b0));
            end
        end
    endtask

    task automatic test_corner_vectors();
        // A load with last set writes its entry and must not produce a result.
        send_item(make_item(MODE_LOAD, 4'd15, 3'd7, 8'h80, 1'b1));
        send_vector({NUM_AP{8'h7F}});
        send_item(make_item(MODE_MEASURE, 4'd0, 3'd3, 8'h80, 1'b1));
        send_vector({NUM_AP{8'h80}});
    endtask

    task automatic test_limit_extremes();
        wait_idle();
        write_limit(20'd0);
        send_item(make_item(MODE_MEASURE, 4'd9, 3'd0, 8'h00, 1'b1));
        send_vector({NUM_AP{8'h7F}});
        wait_idle();
        write_limit(DIST_MAX);
        send_item(make_item(MODE_MEASURE, 4'd6, 3'd5, 8'h7F, 1'b1));
        send_vector({NUM_AP{8'h80}});
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        write_limit(LIMIT_RESET);
        set_idling(0, 0);
        hold_request <= hold_request + 1;
        send_vector({NUM_AP{8'h7F}});
        repeat (4)
            send_item(make_item(MODE_LOAD, 4'($urandom_range(1, 7)), 3'($urandom_range(7)),
                                8'($urandom_range(255)), 1'b0));
        send_vector({NUM_AP{8'h80}});
        repeat (4)
            send_item(make_item(MODE_LOAD, 4'($urandom_range(9, 14)), 3'($urandom_range(7)),
                                8'($urandom_range(255)), 1'b0));
        send_item(make_item(MODE_MEASURE, 4'd0, 3'd1, 8'h10, 1'b1));
        wait_idle();
    endtask

    task automatic random_sequence();
        int               kind;
        int               n;
        int               row;
        logic [7:0][7:0]  vec;
        logic [7:0]       delta;
        kind = $urandom_range(99);
        if (kind < 10) begin
            n = $urandom_range(1, 4);
            repeat (n)
                send_item(make_item(1'($urandom_range(1)), 4'($urandom_range(15)),
                                    3'($urandom_range(7)), 8'($urandom_range(255)),
                                    1'($urandom_range(1))));
        end else begin
            n = $urandom_range(0, 6);
            repeat (n)
                send_item(make_item(MODE_LOAD, 4'($urandom_range(15)), 3'($urandom_range(7)),
                                    8'($urandom_range(255)), $urandom_range(7) == 0));
            if ($urandom_range(9) < 7) begin
                // Mostly a small perturbation of one stored row, so some searches find it.
                row = $urandom_range(NUM_LOC - 1);
                for (int ap = 0; ap < NUM_AP; ap++) begin
                    delta = 8'($urandom_range(16));
                    if ($urandom_range(3) != 0)
                        vec[ap] = fp_table[row][ap] + delta - 8'd8;
                    else
                        vec[ap] = 8'($urandom_range(255));
                end
                send_vector(vec);
            end else begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                    send_item(make_item(MODE_MEASURE, 4'($urandom_range(15)),
                                        3'($urandom_range(7)), 8'($urandom_range(255)),
                                        k == n - 1));
            end
        end
    endtask

    task automatic test_random_phase(input int in_pct, input int out_pct,
                                     input logic [19:0] limit, input int num_items);
        int target;
        wait_idle();
        write_limit(limit);
        set_idling(in_pct, out_pct);
        target = items_sent + num_items;
        while (items_sent < target)
            random_sequence();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_fill();
        test_corner_vectors();
        test_limit_extremes();
        test_output_backpressure();
        test_random_phase(0, 0, LIMIT_RESET, 330);
        test_random_phase(62, 0, 20'($urandom_range(2000)), 330);
        test_random_phase(0, 62, 20'($urandom_range(600)), 330);
        test_random_phase(20, 20, 20'($urandom_range(5000)), 330);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
